// ----- rtl/core/dstwr_pkg.sv -----
`timescale 1ns / 1ps
// Package: shared types, constants and command codes for the ranging median gate.
package dstwr_pkg;

  localparam int unsigned NUM_PEERS_DEF = 8;
  localparam int unsigned TS_W          = 32;
  localparam int unsigned MM_W          = 20;
  localparam int unsigned THR_W         = 16;
  localparam int unsigned DIST_W        = 16;
  localparam int unsigned PEER_W        = 3;
  localparam int unsigned CFG_W         = 20;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned DIV_STEPS     = DIST_W;

  localparam logic [MM_W-1:0]      MM_PER_TICK_RST = 20'd307479;
  localparam logic [THR_W-1:0]     THRESHOLD_RST   = 16'd500;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MM      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THR     = 1'b1;

  typedef struct packed {
    logic              func;
    logic [PEER_W-1:0] peer_id;
    logic [TS_W-1:0]   poll_sent_time;
    logic [TS_W-1:0]   poll_heard_time;
    logic [TS_W-1:0]   answer_sent_time;
    logic [TS_W-1:0]   answer_heard_time;
    logic [TS_W-1:0]   final_sent_time;
    logic [TS_W-1:0]   final_heard_time;
    logic [DIST_W-1:0] given_distance_mm;
  } in_item_t;

  typedef struct packed {
    logic [PEER_W-1:0] peer_out;
    logic [DIST_W-1:0] raw_distance_mm;
    logic [DIST_W-1:0] filtered_distance_mm;
    logic              valid_res;
    logic              outlier;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_MUL_A,
    DP_MUL_B,
    DP_SUB,
    DP_MUL_LO,
    DP_MUL_HI,
    DP_ALIGN,
    DP_DIV_STEP,
    DP_RAW_ZERO,
    DP_RAW_SAT,
    DP_RAW_QUOT,
    DP_MED,
    DP_GATE
  } dp_op_e;

  typedef struct packed {
    logic func;
    logic num_zero;
    logic sat;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/core/dstwr_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: timestamp arithmetic, shared multiplier, restoring divider, history and gate.
module dstwr_datapath import dstwr_pkg::*; #(
  parameter int unsigned NUM_PEERS = NUM_PEERS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  in_item_t             in_data_i,
  input  dp_op_e               op_i,
  output dp_status_t           status_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o
);

  localparam int unsigned PW      = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
  localparam int unsigned SUM_W   = TS_W + 2;
  localparam int unsigned PROD_W  = 2 * TS_W;
  localparam int unsigned SCL_W   = TS_W + MM_W;
  localparam logic [1:0]  POS_LAST = 2'd2;

  typedef struct packed {
    logic [1:0]             pos;
    logic [2:0][DIST_W-1:0] h;
  } hist_row_t;

  function automatic logic [DIST_W-1:0] mid3(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b,
                                             input logic [DIST_W-1:0] c);
    logic [DIST_W-1:0] m;
    if (a <= b && a <= c) begin
      m = (b <= c) ? b : c;
    end else if (b <= a && b <= c) begin
      m = (a <= c) ? a : c;
    end else begin
      m = (a <= b) ? a : b;
    end
    return m;
  endfunction

  // Configuration registers.
  logic [MM_W-1:0]  mm_q;
  logic [THR_W-1:0] thr_q;

  // Item registers.
  logic              func_q;
  logic [PEER_W-1:0] peer_q;
  logic [PW-1:0]     idx_q;
  logic [TS_W-1:0]   round1_q, reply1_q, round2_q, reply2_q;
  logic [SUM_W-1:0]  sum_q;
  logic [PROD_W-1:0] pa_q, pb_q, num_q;
  logic              num_zero_q;
  logic [SCL_W-1:0]  rem_q;
  logic [DIST_W-1:0] low_q, quot_q, raw_q, med_q;

  // History memory, one row per peer; a row without its valid bit reads as zero.
  hist_row_t         mem_q [NUM_PEERS];
  logic [NUM_PEERS-1:0] row_vld_q;
  hist_row_t         rd_row_q;
  logic              rd_vld_q;

  // Output register.
  logic              out_vld_q;
  out_item_t         out_q;

  logic [PW-1:0]     idx_in;
  logic [TS_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [PROD_W:0]   sub_full;
  logic [SUM_W:0]    div_t;
  logic [SUM_W+1:0]  div_sub;
  logic              div_ge;
  hist_row_t         row_eff, row_new;
  logic              in_range, upd, is_outl;
  logic [DIST_W-1:0] delta, filt;
  logic [1:0]        pos_nxt;

  assign idx_in = PW'(in_data_i.peer_id);

  // The one multiplier is shared by the two timestamp products and the two scale products.
  always_comb begin
    unique case (op_i)
      DP_MUL_A:  begin mul_a = round1_q;            mul_b = round2_q;         end
      DP_MUL_B:  begin mul_a = reply1_q;            mul_b = reply2_q;         end
      DP_MUL_LO: begin mul_a = num_q[TS_W-1:0];     mul_b = TS_W'(mm_q);      end
      DP_MUL_HI: begin mul_a = num_q[PROD_W-1:TS_W]; mul_b = TS_W'(mm_q);     end
      default:   begin mul_a = '0;                  mul_b = '0;               end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // A borrow or an all-zero difference means the numerator is not positive.
  assign sub_full = {1'b0, pa_q} - {1'b0, pb_q};

  // One restoring step: bring down the next dividend bit and try the subtract.
  assign div_t   = {rem_q[SUM_W-1:0], low_q[DIST_W-1]};
  assign div_sub = {1'b0, div_t} - {2'b00, sum_q};
  assign div_ge  = ~div_sub[SUM_W+1];

  assign status_o.func     = func_q;
  assign status_o.num_zero = num_zero_q;
  assign status_o.sat      = (rem_q >= SCL_W'(sum_q));
  assign status_o.out_free = ~out_vld_q | out_ready_i;

  // Gate logic on the stored row.
  always_comb begin
    row_eff  = rd_vld_q ? rd_row_q : '0;
    in_range = (int'(peer_q) < int'(NUM_PEERS));
    upd      = (raw_q != '0) && in_range;
    delta    = (med_q > raw_q) ? (med_q - raw_q) : (raw_q - med_q);
    is_outl  = upd && (delta > thr_q);
    if (!upd) begin
      filt = '0;
    end else if (is_outl) begin
      filt = med_q;
    end else begin
      filt = raw_q;
    end
    pos_nxt     = (row_eff.pos >= POS_LAST) ? 2'd0 : row_eff.pos + 2'd1;
    row_new     = row_eff;
    row_new.pos = pos_nxt;
    unique case (pos_nxt)
      2'd0:    row_new.h[0] = raw_q;
      2'd1:    row_new.h[1] = raw_q;
      default: row_new.h[2] = raw_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_q  <= MM_PER_TICK_RST;
      thr_q <= THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IDX_MM:  mm_q  <= cfg_data_i[MM_W-1:0];
        CFG_IDX_THR: thr_q <= cfg_data_i[THR_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      func_q   <= in_data_i.func;
      peer_q   <= in_data_i.peer_id;
      idx_q    <= idx_in;
      raw_q    <= in_data_i.given_distance_mm;
      round1_q <= in_data_i.answer_heard_time - in_data_i.poll_sent_time;
      reply1_q <= in_data_i.answer_sent_time - in_data_i.poll_heard_time;
      round2_q <= in_data_i.final_heard_time - in_data_i.answer_sent_time;
      reply2_q <= in_data_i.final_sent_time - in_data_i.answer_heard_time;
    end
    unique case (op_i)
      DP_MUL_A: begin
        pa_q  <= mul_p;
        sum_q <= SUM_W'(round1_q) + SUM_W'(round2_q) + SUM_W'(reply1_q) + SUM_W'(reply2_q);
      end
      DP_MUL_B: pb_q <= mul_p;
      DP_SUB: begin
        num_q      <= sub_full[PROD_W-1:0];
        num_zero_q <= sub_full[PROD_W] || (sub_full[PROD_W-1:0] == '0) || (sum_q == '0);
      end
      // The low and high scale products reuse the two product registers.
      DP_MUL_LO: pa_q <= mul_p;
      DP_MUL_HI: pb_q <= mul_p;
      DP_ALIGN: begin
        rem_q <= pb_q[SCL_W-1:0] + SCL_W'(pa_q[SCL_W-1:TS_W]);
        low_q <= pa_q[TS_W-1:TS_W-DIST_W];
      end
      DP_DIV_STEP: begin
        rem_q  <= div_ge ? SCL_W'(div_sub[SUM_W-1:0]) : SCL_W'(div_t);
        low_q  <= {low_q[DIST_W-2:0], 1'b0};
        quot_q <= {quot_q[DIST_W-2:0], div_ge};
      end
      DP_RAW_ZERO: raw_q <= '0;
      DP_RAW_SAT:  raw_q <= '1;
      DP_RAW_QUOT: raw_q <= quot_q;
      DP_MED:      med_q <= mid3(row_eff.h[0], row_eff.h[1], row_eff.h[2]);
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rd_row_q <= mem_q[idx_in];
    end
    if (op_i == DP_GATE && upd) begin
      mem_q[idx_q] <= row_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (load_i) begin
        rd_vld_q <= row_vld_q[idx_in];
      end
      if (op_i == DP_GATE && upd) begin
        row_vld_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (op_i == DP_GATE) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == DP_GATE) begin
      out_q.peer_out             <= peer_q;
      out_q.raw_distance_mm      <= raw_q;
      out_q.filtered_distance_mm <= filt;
      out_q.valid_res            <= upd;
      out_q.outlier              <= is_outl;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/dstwr_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences the datapath through products, scaling, division and the gate.
module dstwr_ctrl import dstwr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  dp_status_t status_i,
  output dp_op_e     op_o,
  output logic       in_ready_o
);

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_PROD_A,
    S_PROD_B,
    S_DIFF,
    S_SCALE_LO,
    S_SCALE_HI,
    S_ALIGN,
    S_RANGE,
    S_DIV,
    S_FIX,
    S_MED,
    S_GATE,
    S_WRITE
  } state_e;

  state_e         state_q;
  dp_op_e         op_q;
  logic           in_ready_q;
  logic [CNT_W-1:0] cnt_q;

  // op_q is the datapath operation carried out in the current state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= DP_IDLE;
      in_ready_q <= 1'b1;
      cnt_q      <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          op_q <= DP_IDLE;
          if (accept_i) begin
            in_ready_q <= 1'b0;
            state_q    <= S_START;
          end
        end
        S_START: begin
          if (status_i.func) begin
            op_q    <= DP_MED;
            state_q <= S_MED;
          end else begin
            op_q    <= DP_MUL_A;
            state_q <= S_PROD_A;
          end
        end
        S_PROD_A: begin
          op_q    <= DP_MUL_B;
          state_q <= S_PROD_B;
        end
        S_PROD_B: begin
          op_q    <= DP_SUB;
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          op_q    <= DP_MUL_LO;
          state_q <= S_SCALE_LO;
        end
        S_SCALE_LO: begin
          if (status_i.num_zero) begin
            op_q    <= DP_RAW_ZERO;
            state_q <= S_FIX;
          end else begin
            op_q    <= DP_MUL_HI;
            state_q <= S_SCALE_HI;
          end
        end
        S_SCALE_HI: begin
          op_q    <= DP_ALIGN;
          state_q <= S_ALIGN;
        end
        S_ALIGN: begin
          op_q    <= DP_IDLE;
          state_q <= S_RANGE;
        end
        S_RANGE: begin
          // A leading remainder not below the sum means the quotient needs more than 16 bits.
          if (status_i.sat) begin
            op_q    <= DP_RAW_SAT;
            state_q <= S_FIX;
          end else begin
            op_q    <= DP_DIV_STEP;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
            op_q    <= DP_RAW_QUOT;
            state_q <= S_FIX;
          end else begin
            op_q <= DP_DIV_STEP;
          end
        end
        S_FIX: begin
          op_q    <= DP_MED;
          state_q <= S_MED;
        end
        S_MED: begin
          op_q    <= DP_IDLE;
          state_q <= S_GATE;
        end
        S_GATE: begin
          if (status_i.out_free) begin
            op_q    <= DP_GATE;
            state_q <= S_WRITE;
          end else begin
            op_q <= DP_IDLE;
          end
        end
        S_WRITE: begin
          op_q       <= DP_IDLE;
          in_ready_q <= 1'b1;
          state_q    <= S_IDLE;
        end
        default: begin
          op_q       <= DP_IDLE;
          in_ready_q <= 1'b1;
          state_q    <= S_IDLE;
        end
      endcase
    end
  end

  assign op_o       = op_q;
  assign in_ready_o = in_ready_q;

endmodule

// ----- rtl/core/ds_twr_range_median_gate_unit.sv -----
`timescale 1ns / 1ps
// Top level: double-sided two-way ranging distance with a per-peer median gate.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o  in_data_i  (in_item_t)
//   out      output     out_valid_o/out_ready_i out_data_o (out_item_t)
//   cfg      input      cfg_we_i               cfg_index_i, cfg_data_i
//
// The 16 restoring divider steps dominate a timestamp item's path from its transfer to the
// earliest result transfer, one quotient bit per cycle; a supplied distance skips them.
// A finished result waits in the output register; the next item is taken meanwhile and
// only stalls at its gate step if that register is still full.
// Reset clears the history valid bits at once, so no clearing pass is needed.
module ds_twr_range_median_gate_unit import dstwr_pkg::*; #(
  parameter int unsigned NUM_PEERS = NUM_PEERS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic       accept;
  dp_op_e     op;
  dp_status_t status;

  assign accept = in_valid_i & in_ready_o;

  dstwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .status_i   (status),
    .op_o       (op),
    .in_ready_o (in_ready_o)
  );

  dstwr_datapath #(
    .NUM_PEERS (NUM_PEERS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .in_data_i   (in_data_i),
    .op_i        (op),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
